/* hdl/wst_pkg.sv */
// ----------------------------------------------------------------------------
// Wave stencil time step package
// Shared widths, register indexes and payload types for the stencil block.
// ----------------------------------------------------------------------------
package wst_pkg;

  localparam int VALUE_WIDTH            = 32;
  localparam int COEF_WIDTH             = 32;
  localparam int COEF_LO_BITS           = 15;
  localparam int COEF_FRAC              = 30;
  localparam int WIN_DEPTH              = 7;
  localparam int PREV_DEPTH             = 4;
  localparam int DIFF_WIDTH             = VALUE_WIDTH + 7;
  localparam int TOTAL_WIDTH            = DIFF_WIDTH + COEF_WIDTH + 5;
  localparam int OUT_FIFO_DEPTH         = 8;
  localparam int DEFAULT_MAX_ROW_POINTS = 1024;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_SECOND = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_FOURTH = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_SIXTH  = 2'd3;

  localparam logic [1:0] HALF_WIDTH_ONE   = 2'd1;
  localparam logic [1:0] HALF_WIDTH_TWO   = 2'd2;
  localparam logic [1:0] HALF_WIDTH_THREE = 2'd3;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    value_t u_next;
    logic   last_of_row;
    logic   saturated;
  } result_t;

endpackage

/* hdl/wave_stencil_time_step.sv */
// ----------------------------------------------------------------------------
// Wave stencil time step
// Streams one grid row and produces the next time level at interior points.
// ----------------------------------------------------------------------------
// Input transactions carry u_now, u_prev, row_start and row_end for one grid
// point; a transaction completes when in_valid is high and in_stall is low.
// Once 2h+1 points of a row have arrived, each further point yields one output
// transaction with the next value at the window centre, h points back.
// The window is a chain of seven tap cells plus four for the previous level.
// The block takes one point per cycle while in_stall is low. Results wait in
// an eight-entry queue while out_stall is high; in_stall rises only when the
// queue and the points still in the pipeline fill those eight entries.
// Configuration writes through cfg_write, cfg_index and cfg_data are to be
// made by the user only while the block is idle; the block itself does not
// enforce this. Reset sets half width one, clears the coefficients, the
// window, the point count and the queue.
// ----------------------------------------------------------------------------
module wave_stencil_time_step import wst_pkg::*; #(
  parameter int MAX_ROW_POINTS = DEFAULT_MAX_ROW_POINTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COEF_WIDTH-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  value_t                     u_now,
  input  value_t                     u_prev,
  input  logic                       row_start,
  input  logic                       row_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output value_t                     u_next,
  output logic                       last_of_row,
  output logic                       saturated
);

  localparam int CNT_W  = $clog2(MAX_ROW_POINTS + 1);
  localparam int FCNT_W = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int OCC_W  = FCNT_W + 1;

  logic [1:0] half_width, half_eff;
  coef_t coef_second, coef_fourth, coef_sixth;
  logic [CNT_W-1:0] points_seen, count;
  logic item_valid, in_acc;
  tag_t tag0, tag_res;
  value_t win [WIN_DEPTH];
  value_t prev [PREV_DEPTH];
  result_t result, head;
  logic [2:0] busy;
  logic [FCNT_W-1:0] fifo_count;
  logic [OCC_W-1:0] occupancy;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width  <= HALF_WIDTH_ONE;
      coef_second <= '0;
      coef_fourth <= '0;
      coef_sixth  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HALF_WIDTH:  half_width  <= cfg_data[1:0];
        REG_COEF_SECOND: coef_second <= cfg_data;
        REG_COEF_FOURTH: coef_fourth <= cfg_data;
        REG_COEF_SIXTH:  coef_sixth  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A half width of zero runs as second order.
  assign half_eff = (half_width == 2'd0) ? HALF_WIDTH_ONE : half_width;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    if (row_start) begin
      count = CNT_W'(1);
    end else if (points_seen == CNT_W'(MAX_ROW_POINTS)) begin
      count = points_seen;
    end else begin
      count = points_seen + 1'b1;
    end
    item_valid = count >= CNT_W'({half_eff, 1'b1});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= '0;
      tag0        <= '0;
    end else begin
      if (in_acc) begin
        points_seen <= row_end ? '0 : count;
      end
      tag0.valid <= in_acc && item_valid;
      tag0.last  <= row_end;
    end
  end

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_now
    wst_tap_cell #(.WIDTH(VALUE_WIDTH)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (in_acc),
      .clear ((i != 0) && row_start),
      .d     ((i == 0) ? u_now : win[(i == 0) ? 0 : i - 1]),
      .q     (win[i])
    );
  end

  for (genvar i = 0; i < PREV_DEPTH; i++) begin : g_prev
    wst_tap_cell #(.WIDTH(VALUE_WIDTH)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (in_acc),
      .clear ((i != 0) && row_start),
      .d     ((i == 0) ? u_prev : prev[(i == 0) ? 0 : i - 1]),
      .q     (prev[i])
    );
  end

  wst_stencil_calc u_calc (
    .clk         (clk),
    .rst         (rst),
    .win         (win),
    .prev        (prev),
    .half_width  (half_eff),
    .coef_second (coef_second),
    .coef_fourth (coef_fourth),
    .coef_sixth  (coef_sixth),
    .tag_in      (tag0),
    .tag_out     (tag_res),
    .result      (result),
    .busy        (busy)
  );

  wst_out_fifo #(.DEPTH(OUT_FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (tag_res.valid),
    .wr_data  (result),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (head),
    .count    (fifo_count)
  );

  assign occupancy   = OCC_W'(fifo_count) + OCC_W'(tag0.valid) + OCC_W'(busy);
  assign in_stall    = occupancy >= OCC_W'(OUT_FIFO_DEPTH);
  assign u_next      = head.u_next;
  assign last_of_row = head.last_of_row;
  assign saturated   = head.saturated;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    tag_res.valid |-> fifo_count < FCNT_W'(OUT_FIFO_DEPTH))
    else $error("result written into a full output queue");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(OUT_FIFO_DEPTH))
    else $error("queued and in-flight results exceed the queue depth");

  a_row_count: assert property (@(posedge clk) disable iff (rst)
    in_acc && row_start && !row_end |=> points_seen == CNT_W'(1))
    else $error("row start did not restart the point count");

  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    in_acc && row_start |=> win[0] == $past(u_now) && win[1] == '0 && win[6] == '0
      && prev[1] == '0)
    else $error("row start did not clear the window");

endmodule

/* hdl/wst_tap_cell.sv */
// ----------------------------------------------------------------------------
// Wave stencil tap cell
// One window entry; takes its neighbor's value, or zero when clear is set, on each accepted transaction.
// ----------------------------------------------------------------------------
module wst_tap_cell #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             clear,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= clear ? '0 : d;
    end
  end

endmodule

/* hdl/wst_stencil_calc.sv */
// ----------------------------------------------------------------------------
// Wave stencil arithmetic pipeline
// Differences, split-coefficient products, sum, rounding and saturation.
// ----------------------------------------------------------------------------
module wst_stencil_calc import wst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  value_t     win [WIN_DEPTH],
  input  value_t     prev [PREV_DEPTH],
  input  logic [1:0] half_width,
  input  coef_t      coef_second,
  input  coef_t      coef_fourth,
  input  coef_t      coef_sixth,
  input  tag_t       tag_in,
  output tag_t       tag_out,
  output result_t    result,
  output logic [2:0] busy
);

  localparam int PH_W = DIFF_WIDTH + COEF_WIDTH - COEF_LO_BITS;
  localparam int PL_W = DIFF_WIDTH + COEF_LO_BITS + 1;
  localparam int RW   = TOTAL_WIDTH - COEF_FRAC;

  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PH_W-1:0]        prod_hi_t;
  typedef logic signed [PL_W-1:0]        prod_lo_t;
  typedef logic signed [PH_W+1:0]        sum_hi_t;
  typedef logic signed [PL_W+1:0]        sum_lo_t;
  typedef logic signed [TOTAL_WIDTH-1:0] total_t;

  diff_t w [WIN_DEPTH];
  diff_t d2_c, d4_c, d6_c, base_c;
  diff_t d2, d4, d6, base1, base2, base3;
  prod_hi_t ph2, ph4, ph6;
  prod_lo_t pl2, pl4, pl6;
  sum_hi_t hi_sum;
  sum_lo_t lo_sum;
  total_t total;
  tag_t tag1, tag2, tag3, tag4;
  logic signed [RW-1:0] rounded;
  logic [RW-VALUE_WIDTH:0] upper;
  logic pos_ovf, neg_ovf;

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      w[i] = diff_t'(win[i]);
    end
    d4_c = '0;
    d6_c = '0;
    case (half_width)
      HALF_WIDTH_TWO: begin
        d2_c   = w[3] - (w[2] <<< 1) + w[1];
        d4_c   = w[4] - (w[3] <<< 2) + 6 * w[2] - (w[1] <<< 2) + w[0];
        base_c = (w[2] <<< 1) - diff_t'(prev[2]);
      end
      HALF_WIDTH_THREE: begin
        d2_c   = w[4] - (w[3] <<< 1) + w[2];
        d4_c   = w[5] - (w[4] <<< 2) + 6 * w[3] - (w[2] <<< 2) + w[1];
        d6_c   = w[6] - 6 * w[5] + 15 * w[4] - 20 * w[3] + 15 * w[2] - 6 * w[1] + w[0];
        base_c = (w[3] <<< 1) - diff_t'(prev[3]);
      end
      default: begin
        d2_c   = w[2] - (w[1] <<< 1) + w[0];
        base_c = (w[1] <<< 1) - diff_t'(prev[1]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
    end else begin
      tag1 <= tag_in;
      tag2 <= tag1;
      tag3 <= tag2;
      tag4 <= tag3;
    end
  end

  always_ff @(posedge clk) begin
    d2    <= d2_c;
    d4    <= d4_c;
    d6    <= d6_c;
    base1 <= base_c;

    ph2   <= d2 * signed'(coef_second[COEF_WIDTH-1:COEF_LO_BITS]);
    ph4   <= d4 * signed'(coef_fourth[COEF_WIDTH-1:COEF_LO_BITS]);
    ph6   <= d6 * signed'(coef_sixth[COEF_WIDTH-1:COEF_LO_BITS]);
    pl2   <= d2 * signed'({1'b0, coef_second[COEF_LO_BITS-1:0]});
    pl4   <= d4 * signed'({1'b0, coef_fourth[COEF_LO_BITS-1:0]});
    pl6   <= d6 * signed'({1'b0, coef_sixth[COEF_LO_BITS-1:0]});
    base2 <= base1;

    hi_sum <= sum_hi_t'(ph2) + sum_hi_t'(ph4) + sum_hi_t'(ph6);
    lo_sum <= sum_lo_t'(pl2) + sum_lo_t'(pl4) + sum_lo_t'(pl6);
    base3  <= base2;

    total <= (total_t'(base3) <<< COEF_FRAC) + (total_t'(hi_sum) <<< COEF_LO_BITS)
           + total_t'(lo_sum) + (total_t'(1) <<< (COEF_FRAC - 1));
  end

  // The half-step offset was added above, so a floor shift rounds halves up.
  always_comb begin
    rounded = total[TOTAL_WIDTH-1:COEF_FRAC];
    upper   = rounded[RW-1:VALUE_WIDTH-1];
    pos_ovf = !rounded[RW-1] && (|upper);
    neg_ovf = rounded[RW-1] && !(&upper);
    if (pos_ovf) begin
      result.u_next = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end else if (neg_ovf) begin
      result.u_next = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      result.u_next = rounded[VALUE_WIDTH-1:0];
    end
    result.last_of_row = tag4.last;
    result.saturated   = pos_ovf || neg_ovf;
  end

  assign tag_out = tag4;
  assign busy    = 3'($countones({tag1.valid, tag2.valid, tag3.valid, tag4.valid}));

endmodule

/* hdl/wst_out_fifo.sv */
// ----------------------------------------------------------------------------
// Wave stencil output queue
// Small register queue that holds results while the receiver stalls.
// ----------------------------------------------------------------------------
module wst_out_fifo import wst_pkg::*; #(
  parameter int DEPTH = OUT_FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  result_t                    wr_data,
  output logic                       rd_valid,
  input  logic                       rd_stall,
  output result_t                    rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic pop;

  assign rd_valid = count != '0;
  assign pop      = rd_valid && !rd_stall;
  assign rd_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr_en) - CNT_W'(pop);
    end
  end

endmodule

/* tb/wave_stencil_time_step_test.sv */
// ----------------------------------------------------------------------------
// Wave stencil time step testbench
// Streams grid rows through the stencil block with random idling on both
// channels. A table of directed points covers the extremes, the row framing
// cases and the rounding of ties. Random rows follow under several register
// settings, before and after one row longer than the point count limit. Every
// result is checked against a table entry or an exact wide-integer predictor.
// ----------------------------------------------------------------------------
module wave_stencil_time_step_test;
  import wst_pkg::*;

  localparam int ROW_POINT_LIMIT = DEFAULT_MAX_ROW_POINTS;
  localparam int CYCLE_LIMIT     = 400000;

  typedef logic signed [127:0] wide_t;

  typedef enum logic [1:0] {ROW_SETUP, ROW_POINT, ROW_TYPED, ROW_SILENT} row_kind_t;

  typedef struct packed {
    value_t now_v;
    value_t prev_v;
    logic   row_first;
    logic   row_last;
  } point_t;

  typedef struct {
    row_kind_t  kind;
    logic [1:0] hw;
    coef_t      c2;
    coef_t      c4;
    coef_t      c6;
    point_t     pt;
    result_t    res;
  } step_row_t;

  localparam result_t NO_RESULT = '0;
  localparam wide_t   TOP_VALUE = (wide_t'(1) <<< (VALUE_WIDTH - 1)) - 1;
  localparam wide_t   LOW_VALUE = -(wide_t'(1) <<< (VALUE_WIDTH - 1));

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [COEF_WIDTH-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  value_t                     u_now = '0;
  value_t                     u_prev = '0;
  logic                       row_start = 1'b0;
  logic                       row_end = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  value_t                     u_next;
  logic                       last_of_row;
  logic                       saturated;

  // Predictor state.
  logic [1:0] half_cfg;
  coef_t      k2;
  coef_t      k4;
  coef_t      k6;
  value_t     cur_taps[WIN_DEPTH];
  value_t     old_taps[3];
  int         row_count;

  result_t    predicted_next[$];
  result_t    want;
  step_row_t  plan[$];
  point_t     pt;
  int         errors = 0;
  int         cycles = 0;
  int         gap_odds = 0;
  int         stall_odds = 0;
  int         stall_left = 0;

  wave_stencil_time_step #(.MAX_ROW_POINTS(ROW_POINT_LIMIT)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .u_now(u_now),
    .u_prev(u_prev),
    .row_start(row_start),
    .row_end(row_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .u_next(u_next),
    .last_of_row(last_of_row),
    .saturated(saturated)
  );

  always #1 clk = ~clk;

  function automatic void clear_window();
    foreach (cur_taps[i]) cur_taps[i] = '0;
    foreach (old_taps[i]) old_taps[i] = '0;
    row_count = 0;
  endfunction

  function automatic bit advance_row(input point_t p, output result_t res);
    int    h;
    int    count;
    value_t centre_old;
    wide_t d2;
    wide_t d4;
    wide_t d6;
    wide_t total;
    wide_t rounded;
    h = (half_cfg == 2'd0) ? 1 : int'(half_cfg);
    res = NO_RESULT;
    if (p.row_first) begin
      clear_window();
    end
    centre_old = old_taps[h-1];
    for (int i = WIN_DEPTH - 1; i > 0; i--) cur_taps[i] = cur_taps[i-1];
    cur_taps[0] = p.now_v;
    for (int i = 2; i > 0; i--) old_taps[i] = old_taps[i-1];
    old_taps[0] = p.prev_v;
    count = (row_count + 1 > ROW_POINT_LIMIT) ? ROW_POINT_LIMIT : row_count + 1;
    row_count = p.row_last ? 0 : count;
    if (count < 2 * h + 1) return 1'b0;

    d2 = wide_t'(cur_taps[h+1]) - 2 * wide_t'(cur_taps[h]) + wide_t'(cur_taps[h-1]);
    total = (2 * wide_t'(cur_taps[h]) - wide_t'(centre_old)) <<< COEF_FRAC;
    total = total + d2 * wide_t'(k2);
    if (h >= 2) begin
      d4 = wide_t'(cur_taps[h+2]) - 4 * wide_t'(cur_taps[h+1]) + 6 * wide_t'(cur_taps[h])
         - 4 * wide_t'(cur_taps[h-1]) + wide_t'(cur_taps[h-2]);
      total = total + d4 * wide_t'(k4);
    end
    if (h >= 3) begin
      d6 = wide_t'(cur_taps[6]) - 6 * wide_t'(cur_taps[5]) + 15 * wide_t'(cur_taps[4])
         - 20 * wide_t'(cur_taps[3]) + 15 * wide_t'(cur_taps[2])
         - 6 * wide_t'(cur_taps[1]) + wide_t'(cur_taps[0]);
      total = total + d6 * wide_t'(k6);
    end
    // Ties round toward plus infinity.
    rounded = (total + (wide_t'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    res.saturated = 1'b0;
    if (rounded > TOP_VALUE) begin
      rounded = TOP_VALUE;
      res.saturated = 1'b1;
    end
    if (rounded < LOW_VALUE) begin
      rounded = LOW_VALUE;
      res.saturated = 1'b1;
    end
    res.u_next = rounded[VALUE_WIDTH-1:0];
    res.last_of_row = p.row_last;
    return 1'b1;
  endfunction

  function automatic step_row_t point_row(input row_kind_t kind, input value_t n,
                                          input value_t p, input logic s, input logic e,
                                          input result_t res);
    step_row_t row;
    row.kind = kind;
    row.hw = '0;
    row.c2 = '0;
    row.c4 = '0;
    row.c6 = '0;
    row.pt = '{n, p, s, e};
    row.res = res;
    return row;
  endfunction

  function automatic step_row_t setup_row(input logic [1:0] hw, input coef_t c2,
                                          input coef_t c4, input coef_t c6);
    step_row_t row;
    row.kind = ROW_SETUP;
    row.hw = hw;
    row.c2 = c2;
    row.c4 = c4;
    row.c6 = c6;
    row.pt = '0;
    row.res = NO_RESULT;
    return row;
  endfunction

  function automatic value_t random_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7FFFFFFF;
      default: return $signed($urandom()) >>> $urandom_range(3, 12);
    endcase
  endfunction

  function automatic coef_t random_coef();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      default: return $signed($urandom()) >>> $urandom_range(1, 8);
    endcase
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    while (predicted_next.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [COEF_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_HALF_WIDTH:  half_cfg = data[1:0];
      REG_COEF_SECOND: k2 = data;
      REG_COEF_FOURTH: k4 = data;
      REG_COEF_SIXTH:  k6 = data;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [1:0] hw, input coef_t c2, input coef_t c4,
                               input coef_t c6);
    settle();
    write_reg(REG_HALF_WIDTH, ($urandom() & ~32'h3) | {30'd0, hw});
    write_reg(REG_COEF_SECOND, c2);
    write_reg(REG_COEF_FOURTH, c4);
    write_reg(REG_COEF_SIXTH, c6);
    cfg_write <= 1'b0;
  endtask

  task automatic feed(input point_t p, input row_kind_t kind, input result_t typed_res);
    result_t calc;
    bit      hit;
    in_valid <= 1'b1;
    u_now <= p.now_v;
    u_prev <= p.prev_v;
    row_start <= p.row_first;
    row_end <= p.row_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit = advance_row(p, calc);
    case (kind)
      ROW_TYPED:  predicted_next.push_back(typed_res);
      ROW_SILENT: ;
      default:    if (hit) predicted_next.push_back(calc);
    endcase
    if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic stream_rows(input int budget);
    point_t p;
    int     row_len;
    while (budget > 0) begin
      row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      for (int k = 0; k < row_len && budget > 0; k++) begin
        p.now_v = random_value();
        p.prev_v = random_value();
        p.row_first = (k == 0);
        p.row_last = (k == row_len - 1);
        case ($urandom_range(0, 19))
          0: p.row_first = ~p.row_first;
          1: p.row_last = ~p.row_last;
          default: ;
        endcase
        feed(p, ROW_POINT, NO_RESULT);
        budget--;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || stall_odds == 0) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0 && $urandom_range(0, 99) < stall_odds) begin
        stall_left = $urandom_range(1, 15);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (predicted_next.size() == 0) begin
        $display("%0t: result transaction with none expected, u_next actual %h",
                 $time, u_next);
        errors++;
      end else begin
        want = predicted_next.pop_front();
        if (u_next !== want.u_next) begin
          $display("%0t: u_next expected %h actual %h", $time, want.u_next, u_next);
          errors++;
        end
        if (last_of_row !== want.last_of_row) begin
          $display("%0t: last_of_row expected %b actual %b", $time, want.last_of_row,
                   last_of_row);
          errors++;
        end
        if (saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    half_cfg = HALF_WIDTH_ONE;
    k2 = '0;
    k4 = '0;
    k6 = '0;
    clear_window();

    // After reset the coefficients are zero, so each result is 2*u - u_prev.
    plan.push_back(point_row(ROW_SILENT, 32'sh00000000, 32'sh00000000, 1, 0, NO_RESULT));
    plan.push_back(point_row(ROW_SILENT, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, NO_RESULT));
    plan.push_back(point_row(ROW_TYPED, 32'sh00000000, 32'sh00000000, 0, 0,
                             '{32'sh7FFFFFFF, 1'b0, 1'b1}));
    plan.push_back(point_row(ROW_TYPED, 32'sh80000000, 32'sh7FFFFFFF, 0, 0,
                             '{32'sh00000000, 1'b0, 1'b0}));
    plan.push_back(point_row(ROW_TYPED, 32'sh00000000, 32'sh00000000, 0, 1,
                             '{32'sh80000000, 1'b1, 1'b1}));
    // A row that follows a row end without its start flag.
    plan.push_back(point_row(ROW_SILENT, 32'sh08000000, 32'sh02000000, 0, 0, NO_RESULT));
    plan.push_back(point_row(ROW_SILENT, 32'sh10000000, 32'sh04000000, 0, 0, NO_RESULT));
    plan.push_back(point_row(ROW_TYPED, 32'sh00000000, 32'sh00000000, 0, 1,
                             '{32'sh1C000000, 1'b1, 1'b0}));
    // A row too short for the stencil.
    plan.push_back(point_row(ROW_SILENT, 32'sh12345678, 32'sh00000000, 1, 0, NO_RESULT));
    plan.push_back(point_row(ROW_SILENT, 32'sh00000000, 32'sh00000000, 0, 1, NO_RESULT));
    // A row start in the middle of an open row clears the window.
    plan.push_back(point_row(ROW_SILENT, 32'sh55555555, 32'shAAAAAAAA, 0, 0, NO_RESULT));
    plan.push_back(point_row(ROW_SILENT, 32'sh00000000, 32'sh00000000, 1, 0, NO_RESULT));
    plan.push_back(point_row(ROW_SILENT, 32'shF0000000, 32'sh10000000, 0, 0, NO_RESULT));
    plan.push_back(point_row(ROW_TYPED, 32'sh00000000, 32'sh00000000, 0, 1,
                             '{32'shD0000000, 1'b1, 1'b0}));
    // Half width zero acts as one; exact ties in the rounding.
    plan.push_back(setup_row(2'd0, 32'sh00000001, 32'sh7FFFFFFF, 32'sh80000000));
    plan.push_back(point_row(ROW_POINT, 32'sh00000000, 32'sh00000000, 1, 0, NO_RESULT));
    plan.push_back(point_row(ROW_POINT, 32'sh00000000, 32'sh00000000, 0, 0, NO_RESULT));
    plan.push_back(point_row(ROW_TYPED, 32'sh20000000, 32'sh00000000, 0, 0,
                             '{32'sh00000001, 1'b0, 1'b0}));
    plan.push_back(point_row(ROW_POINT, 32'sh20000000, 32'shE0000000, 0, 0, NO_RESULT));
    plan.push_back(point_row(ROW_POINT, 32'sh80000000, 32'sh7FFFFFFF, 0, 1, NO_RESULT));
    // Sixth order with extreme coefficients on an alternating row.
    plan.push_back(setup_row(HALF_WIDTH_THREE, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    for (int i = 0; i < 7; i++) begin
      plan.push_back(point_row(ROW_POINT, (i % 2 == 0) ? 32'sh7FFFFFFF : 32'sh80000000,
                               (i % 2 == 0) ? 32'sh80000000 : 32'sh7FFFFFFF,
                               i == 0, i == 6, NO_RESULT));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    gap_odds = 20;
    stall_odds = 15;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETUP) begin
        load_settings(plan[i].hw, plan[i].c2, plan[i].c4, plan[i].c6);
      end else begin
        feed(plan[i].pt, plan[i].kind, plan[i].res);
      end
    end

    // Phases leave rows open at random, so a new half width lands mid row.
    for (int ph = 0; ph < 10; ph++) begin
      gap_odds = (ph % 3 == 0) ? 0 : $urandom_range(5, 40);
      stall_odds = (ph % 4 == 1) ? 0 : $urandom_range(5, 40);
      load_settings((ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3)),
                    random_coef(), random_coef(), random_coef());
      stream_rows(40);
    end

    // One row past the point count limit.
    gap_odds = 10;
    stall_odds = 10;
    load_settings(HALF_WIDTH_THREE, $signed($urandom()) >>> 2,
                  $signed($urandom()) >>> 5, $signed($urandom()) >>> 7);
    for (int k = 0; k < ROW_POINT_LIMIT + 6; k++) begin
      pt.now_v = $signed($urandom()) >>> 6;
      pt.prev_v = $signed($urandom()) >>> 6;
      pt.row_first = (k == 0);
      pt.row_last = (k == ROW_POINT_LIMIT + 5);
      feed(pt, ROW_POINT, NO_RESULT);
    end

    gap_odds = 0;
    stall_odds = 0;
    load_settings(2'($urandom_range(1, 3)), random_coef(), random_coef(), random_coef());
    stream_rows(100);

    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
